### rtl/crcfp_pkg.sv
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and the CRC-16/CCITT byte update for the frame
// parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

  // framing constants
  localparam logic [7:0]  SYNC_BYTE  = 8'h53;
  localparam logic [7:0]  VERSION_OK = 8'h01;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          HDR_LEN    = 8;
  localparam int          TAIL_LEN   = 2;

  // width of byte counts and frame totals
  localparam int          LEN_W      = 7;

  // front parser phase
  typedef enum logic [1:0] {
    PH_HUNT1   = 2'd0,
    PH_HUNT2   = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // descriptor of one verified frame, handed from front to replay
  typedef struct packed {
    logic [7:0]       frame_type;
    logic [15:0]      frame_sequence;
    logic [LEN_W-1:0] body_len;
    logic             slot;
  } desc_t;

  // CRC-16/CCITT, MSB first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/crcfp_ram.sv
// ----------------------------------------------------------------------------
// crcfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/crcfp_front.sv
// ----------------------------------------------------------------------------
// crcfp_front
// Byte parser: preamble hunt, header capture, version and length check, running CRC,
// payload write into the frame RAM and descriptor push on a CRC match.
// ----------------------------------------------------------------------------
module crcfp_front
  import crcfp_pkg::*;
#(
  parameter int BUFFER_BYTES = 64,
  localparam int PAY_MAX = BUFFER_BYTES - HDR_LEN - TAIL_LEN,
  localparam int PAY_AW  = $clog2(PAY_MAX)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [7:0]        rx_byte,
  output logic              ram_we,
  output logic [PAY_AW:0]   ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              desc_push,
  output desc_t             desc
);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] cnt_r;
  logic [LEN_W-1:0] exp_r;
  logic [15:0]      crc_r;
  logic             wr_slot_r;
  logic [7:0]       ver_r, type_r, seq_lo_r, seq_hi_r, len_lo_r, crc_lo_r;

  logic             is_sync, hdr_end, hdr_bad, frm_end, in_body, crc_lo_hit;
  logic             restart, drop, advance, collect;
  logic [15:0]      body_len;
  logic [7:0]       cnt_p1, cnt_p2, exp_w;

  // byte classification
  assign is_sync    = (rx_byte == SYNC_BYTE);
  assign cnt_p1     = {1'b0, cnt_r} + 8'd1;
  assign cnt_p2     = {1'b0, cnt_r} + 8'd2;
  assign exp_w      = {1'b0, exp_r};
  assign body_len   = {rx_byte, len_lo_r};
  assign hdr_end    = (cnt_r == LEN_W'(HDR_LEN - 1));
  assign hdr_bad    = hdr_end && ((ver_r != VERSION_OK) || (body_len > 16'(PAY_MAX)));
  assign frm_end    = (exp_r != '0) && (cnt_p1 == exp_w);
  assign in_body    = (exp_r != '0) && (cnt_p2 < exp_w);
  assign crc_lo_hit = (exp_r != '0) && (cnt_p2 == exp_w);

  // FSM outputs: events of this beat
  always_comb begin
    restart   = 1'b0;
    drop      = 1'b0;
    advance   = 1'b0;
    collect   = 1'b0;
    if (beat) begin
      unique case (phase_r)
        PH_HUNT1: begin
          restart = 1'b1;
        end
        PH_HUNT2: begin
          restart = !is_sync;
          advance = is_sync;
        end
        default: begin
          if (cnt_r >= LEN_W'(BUFFER_BYTES)) begin
            restart = 1'b1;
          end else begin
            collect = 1'b1;
            drop    = hdr_bad || frm_end;
          end
        end
      endcase
    end
    ram_we    = collect && in_body;
    desc_push = collect && frm_end && ({rx_byte, crc_lo_r} == crc_r);
  end

  // FSM next state
  always_comb begin
    phase_nxt = phase_r;
    if (restart) begin
      phase_nxt = is_sync ? PH_HUNT2 : PH_HUNT1;
    end else if (drop) begin
      phase_nxt = PH_HUNT1;
    end else if (advance) begin
      phase_nxt = PH_COLLECT;
    end
  end

  // RAM write and descriptor
  assign ram_waddr = {wr_slot_r, PAY_AW'(cnt_r - LEN_W'(HDR_LEN))};
  assign ram_wdata = rx_byte;
  always_comb begin
    desc.frame_type     = type_r;
    desc.frame_sequence = {seq_hi_r, seq_lo_r};
    desc.body_len       = exp_r - LEN_W'(HDR_LEN + TAIL_LEN);
    desc.slot           = wr_slot_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT1;
      cnt_r     <= '0;
      exp_r     <= '0;
      crc_r     <= CRC_INIT;
      wr_slot_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (desc_push) begin
        wr_slot_r <= ~wr_slot_r;
      end
      if (restart || drop) begin
        cnt_r <= (restart && is_sync) ? LEN_W'(1) : '0;
        exp_r <= '0;
        crc_r <= CRC_INIT;
      end else if (advance) begin
        cnt_r <= LEN_W'(2);
      end else if (collect) begin
        cnt_r <= cnt_p1[LEN_W-1:0];
        if ((exp_r == '0) || (cnt_p2 < exp_w)) begin
          crc_r <= crc_feed(crc_r, rx_byte);
        end
        if (hdr_end) begin
          exp_r <= body_len[LEN_W-1:0] + LEN_W'(HDR_LEN + TAIL_LEN);
        end
      end
    end
  end

  // header and CRC byte capture
  always_ff @(posedge clk) begin
    if (collect) begin
      unique case (cnt_r)
        LEN_W'(2): ver_r    <= rx_byte;
        LEN_W'(3): type_r   <= rx_byte;
        LEN_W'(4): seq_lo_r <= rx_byte;
        LEN_W'(5): seq_hi_r <= rx_byte;
        LEN_W'(6): len_lo_r <= rx_byte;
        default: begin
          if (crc_lo_hit) begin
            crc_lo_r <= rx_byte;
          end
        end
      endcase
    end
  end

endmodule

### rtl/crcfp_desc_q.sv
// ----------------------------------------------------------------------------
// crcfp_desc_q
// Two-entry queue of verified frame descriptors between parser and replay.
// ----------------------------------------------------------------------------
module crcfp_desc_q
  import crcfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  q_full,
  output logic  q_valid,
  output desc_t head
);

  desc_t      ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = ent_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### rtl/crcfp_replay.sv
// ----------------------------------------------------------------------------
// crcfp_replay
// Replays the payload of the head descriptor from the frame RAM, one result
// per RAM read, into an output register.
// ----------------------------------------------------------------------------
module crcfp_replay
  import crcfp_pkg::*;
#(
  parameter int BUFFER_BYTES = 64,
  localparam int PAY_MAX = BUFFER_BYTES - HDR_LEN - TAIL_LEN,
  localparam int PAY_AW  = $clog2(PAY_MAX)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  desc_t           head,
  output logic            q_pop,
  output logic [PAY_AW:0] ram_raddr,
  input  logic [7:0]      ram_rdata,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      frame_type,
  output logic [15:0]     frame_sequence,
  output logic [5:0]      payload_length,
  output logic [7:0]      payload_byte,
  output logic            has_payload,
  output logic            last
);

  logic [PAY_AW-1:0] rd_idx_r;
  logic              rd_pend_r, out_valid_r;
  logic              pend_has_r, pend_last_r;
  logic [7:0]        pend_type_r;
  logic [15:0]       pend_seq_r;
  logic [5:0]        pend_len_r;
  logic              issue, last_issue, has_body;

  // read issue: one outstanding read, output register free by the time data lands
  assign has_body   = (head.body_len != '0);
  assign issue      = q_valid && !rd_pend_r && (!out_valid_r || pop);
  assign last_issue = !has_body || ((LEN_W'(rd_idx_r) + LEN_W'(1)) == head.body_len);
  assign q_pop      = issue && last_issue;
  assign ram_raddr  = {head.slot, rd_idx_r};
  assign empty      = !out_valid_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        rd_idx_r <= last_issue ? '0 : rd_idx_r + PAY_AW'(1);
      end
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // fields travelling with the outstanding read
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_has_r  <= has_body;
      pend_last_r <= last_issue;
      pend_type_r <= head.frame_type;
      pend_seq_r  <= head.frame_sequence;
      pend_len_r  <= head.body_len[5:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      frame_type     <= pend_type_r;
      frame_sequence <= pend_seq_r;
      payload_length <= pend_len_r;
      payload_byte   <= pend_has_r ? ram_rdata : 8'h00;
      has_payload    <= pend_has_r;
      last           <= pend_last_r;
    end
  end

endmodule

### rtl/crc16_frame_parser.sv
// The first result of a frame follows its last CRC byte through the descriptor queue, the
// frame RAM read and the output register. Throughput: one received byte per cycle while
// full is low; a result's frame RAM read is not issued until the previous one has landed.
// full rises while two verified frames wait for replay; a payload run is taken in order.
// Reset (rst_n low, synchronous) clears parser, queue and replay control; the frame RAM
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// crc16_frame_parser
// Preamble/length/CRC-16 frame parser: front parser, descriptor queue, replay.
// ----------------------------------------------------------------------------
module crc16_frame_parser
  import crcfp_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_frame_type,
  output logic [15:0] out_frame_sequence,
  output logic [5:0]  out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_payload,
  output logic        out_last
);

  localparam int PAY_MAX = BUFFER_BYTES - HDR_LEN - TAIL_LEN;
  localparam int PAY_AW  = $clog2(PAY_MAX);

  logic            beat;
  logic            ram_we;
  logic [PAY_AW:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic            desc_push, q_full, q_valid, q_pop;
  desc_t           push_desc, head;

  assign full = q_full;
  assign beat = push && !q_full;

  crcfp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .rx_byte   (in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .desc_push (desc_push),
    .desc      (push_desc)
  );

  crcfp_ram #(.WIDTH(8), .DEPTH(2 ** (PAY_AW + 1))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crcfp_desc_q u_desc_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  crcfp_replay #(.BUFFER_BYTES(BUFFER_BYTES)) u_replay (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .q_pop          (q_pop),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .empty          (empty),
    .pop            (pop),
    .frame_type     (out_frame_type),
    .frame_sequence (out_frame_sequence),
    .payload_length (out_payload_length),
    .payload_byte   (out_payload_byte),
    .has_payload    (out_has_payload),
    .last           (out_last)
  );

endmodule

### rtl/crcfp_checker.sv
// ----------------------------------------------------------------------------
// crcfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module crcfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_frame_type,
  input logic [15:0] out_frame_sequence,
  input logic [5:0]  out_payload_length,
  input logic [7:0]  out_payload_byte,
  input logic        out_has_payload,
  input logic        out_last
);

  // reset leaves both sides open and nothing waiting
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("results or full after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_payload_byte) && $stable(out_last)
                          && $stable(out_frame_sequence)))
    else $error("stalled result changed");

  // an empty-payload result is a single, zeroed, final beat
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_payload) |->
      (out_last && out_payload_length == 6'd0 && out_payload_byte == 8'd0))
    else $error("malformed empty-payload result");

  // within a run the frame header fields do not change
  a_run_header: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) |=>
      ($stable(out_frame_type) && $stable(out_frame_sequence)
       && $stable(out_payload_length)))
    else $error("header changed inside a payload run");

endmodule

bind crc16_frame_parser crcfp_checker u_chk (.*);
